@@ rtl/core/odt_pkg.sv @@
// Object dictionary table: shared types, codes and helper functions.
`timescale 1ns / 1ps
`default_nettype none
package odt_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 64;

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_READ   = 2'd2;
   localparam logic [1:0] REQ_WRITE  = 2'd3;

   localparam logic [3:0] ST_OK      = 4'd0;
   localparam logic [3:0] ST_INVALID = 4'd1;
   localparam logic [3:0] ST_TYPE    = 4'd2;
   localparam logic [3:0] ST_LENGTH  = 4'd3;
   localparam logic [3:0] ST_DUP     = 4'd4;
   localparam logic [3:0] ST_MISSING = 4'd5;
   localparam logic [3:0] ST_RDENY   = 4'd6;
   localparam logic [3:0] ST_WDENY   = 4'd7;
   localparam logic [3:0] ST_FULL    = 4'd8;

   localparam logic [3:0] TYPE_BOOL     = 4'd0;
   localparam logic [3:0] TYPE_LAST_STD = 4'd13;

   localparam int ACC_RD    = 0;
   localparam int ACC_WR    = 1;
   localparam int ACC_CONST = 2;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] od_index;
      logic [15:0] od_subindex;
      logic [3:0]  value_kind;
      logic [2:0]  access_bits;
      logic [3:0]  byte_count;
      logic [63:0] write_data;
   } req_word_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [63:0] read_data;
      logic [3:0]  read_size;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
   } stat_type;

   function automatic logic [3:0] size_of_type(input logic [3:0] t);
      case (t)
         4'd0, 4'd1, 4'd2:   size_of_type = 4'd1;
         4'd3, 4'd4:         size_of_type = 4'd2;
         4'd5, 4'd6, 4'd7:   size_of_type = 4'd4;
         4'd8, 4'd9, 4'd10:  size_of_type = 4'd8;
         default:            size_of_type = 4'd0;
      endcase
   endfunction

   function automatic logic [63:0] byte_mask(input logic [3:0] n);
      logic [63:0] m;
      m = '0;
      for (int b = 0; b < 8; b++) begin
         if (n > 4'(b)) begin
            m[b*8 +: 8] = 8'hFF;
         end
      end
      byte_mask = m;
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/odt_ctrl.sv @@
// Object dictionary table: request sequencer (load, scan, commit, respond).
`timescale 1ns / 1ps
`default_nettype none
module odt_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output odt_pkg::cmd_type      cmd,
   input  wire odt_pkg::stat_type stat
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // a new word enters only in idle and when the result register can take the old one
   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            cmd.commit   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_commit_after_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> $past(cmd.scan))
      else $error("commit without scan");
   a_rsp_after_commit: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("no result after commit");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !rsp_valid || !rsp_stall)
      else $error("load while result held");

endmodule
`default_nettype wire

@@ rtl/core/odt_datapath.sv @@
// Object dictionary table: slot store, key scan and request evaluation.
`timescale 1ns / 1ps
`default_nettype none
module odt_datapath #(
   parameter int TABLE_DEPTH = odt_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire odt_pkg::req_word_type req_word,
   input  wire odt_pkg::cmd_type      cmd,
   output odt_pkg::stat_type          stat,
   input  wire logic                  rsp_stall,
   output odt_pkg::rsp_word_type      rsp_word
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   // slots read one per cycle during the scan through registered reads, compared in the next cycle
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [23:0] key_mem [TABLE_DEPTH];
   logic [3:0]  type_mem [TABLE_DEPTH];
   logic [2:0]  acc_mem [TABLE_DEPTH];
   logic [3:0]  size_mem [TABLE_DEPTH];
   logic [63:0] value_mem [TABLE_DEPTH];

   odt_pkg::req_word_type req_ff;
   logic [CW-1:0] ptr_ff;
   logic          hit_ff, free_ff;
   logic [AW-1:0] hit_ff_idx, free_idx_ff;
   logic [23:0]   key;
   logic [AW-1:0] ptr_idx;
   logic          ptr_end;
   logic          look_ff, look_used_ff;
   logic [23:0]   look_key_ff;
   logic [AW-1:0] look_idx_ff;
   logic [63:0]   value_rd_ff;
   logic [3:0]    type_rd_ff, size_rd_ff;
   logic [2:0]    acc_rd_ff;
   odt_pkg::rsp_word_type rsp_ff, rsp_in;

   logic [3:0]  tsize, isize, esize, etype;
   logic [2:0]  eacc;
   logic [63:0] wv;
   logic        do_insert, do_remove, do_write;

   assign key     = {req_ff.od_index, req_ff.od_subindex[7:0]};
   assign ptr_idx = ptr_ff[AW-1:0];
   assign ptr_end = (ptr_ff == CW'(TABLE_DEPTH));
   assign stat.scan_done = ptr_end && !look_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_word;
      end
   end

   always_ff @(posedge clock) begin
      look_idx_ff  <= ptr_idx;
      look_key_ff  <= key_mem[ptr_idx];
      look_used_ff <= valid_ff[ptr_idx];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         ptr_ff  <= '0;
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
         look_ff <= 1'b0;
      end else if (cmd.scan) begin
         if (!ptr_end) begin
            ptr_ff <= ptr_ff + CW'(1);
         end
         look_ff <= !ptr_end;
         if (look_ff) begin
            if (look_used_ff && look_key_ff == key && !hit_ff) begin
               hit_ff     <= 1'b1;
               hit_ff_idx <= look_idx_ff;
            end
            if (!look_used_ff && !free_ff) begin
               free_ff     <= 1'b1;
               free_idx_ff <= look_idx_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      value_rd_ff <= value_mem[hit_ff_idx];
      type_rd_ff  <= type_mem[hit_ff_idx];
      acc_rd_ff   <= acc_mem[hit_ff_idx];
      size_rd_ff  <= size_mem[hit_ff_idx];
   end

   assign etype = type_rd_ff;
   assign eacc  = acc_rd_ff;
   assign esize = size_rd_ff;
   assign tsize = odt_pkg::size_of_type(req_ff.value_kind);
   assign isize = (req_ff.byte_count == 4'd0) ? tsize : req_ff.byte_count;
   assign wv    = req_ff.write_data & odt_pkg::byte_mask(esize);

   always_comb begin
      rsp_in    = '0;
      do_insert = 1'b0;
      do_remove = 1'b0;
      do_write  = 1'b0;
      if (req_ff.req_type == odt_pkg::REQ_INSERT) begin
         if (req_ff.od_subindex > 16'h00FF || isize == 4'd0) begin
            rsp_in.status = odt_pkg::ST_INVALID;
         end else if (tsize != 4'd0 && tsize != isize) begin
            rsp_in.status = odt_pkg::ST_TYPE;
         end else if (isize > 4'd8) begin
            rsp_in.status = odt_pkg::ST_LENGTH;
         end else if (hit_ff) begin
            rsp_in.status = odt_pkg::ST_DUP;
         end else if (!free_ff) begin
            rsp_in.status = odt_pkg::ST_FULL;
         end else begin
            do_insert = 1'b1;
         end
      end else if (req_ff.od_subindex > 16'h00FF || !hit_ff) begin
         rsp_in.status = odt_pkg::ST_MISSING;
      end else if (req_ff.req_type == odt_pkg::REQ_REMOVE) begin
         do_remove = 1'b1;
      end else if (req_ff.req_type == odt_pkg::REQ_READ) begin
         if (!eacc[odt_pkg::ACC_RD]) begin
            rsp_in.status = odt_pkg::ST_RDENY;
         end else if (req_ff.byte_count < esize) begin
            rsp_in.status = odt_pkg::ST_LENGTH;
         end else begin
            rsp_in.read_data = value_rd_ff & odt_pkg::byte_mask(esize);
            rsp_in.read_size = esize;
         end
      end else begin
         if (!eacc[odt_pkg::ACC_WR] || eacc[odt_pkg::ACC_CONST]) begin
            rsp_in.status = odt_pkg::ST_WDENY;
         end else if (req_ff.byte_count != esize) begin
            rsp_in.status = odt_pkg::ST_LENGTH;
         end else begin
            do_write = (etype <= odt_pkg::TYPE_LAST_STD);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && do_insert) begin
         key_mem[free_idx_ff]  <= key;
         type_mem[free_idx_ff] <= req_ff.value_kind;
         acc_mem[free_idx_ff]  <= req_ff.access_bits;
         size_mem[free_idx_ff] <= isize;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && do_insert) begin
         value_mem[free_idx_ff] <= '0;
      end else if (cmd.commit && do_write) begin
         value_mem[hit_ff_idx] <= (etype == odt_pkg::TYPE_BOOL) ?
                                  {63'd0, (wv != 64'd0)} : wv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.commit && do_insert) begin
         valid_ff[free_idx_ff] <= 1'b1;
      end else if (cmd.commit && do_remove) begin
         valid_ff[hit_ff_idx] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff <= '0;
      end else if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_word = rsp_ff;

   a_commit_done: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> stat.scan_done)
      else $error("commit before scan finished");
   a_insert_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && do_insert) |-> !valid_ff[free_idx_ff])
      else $error("insert into used slot");
   a_remove_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && do_remove) |=> !valid_ff[$past(hit_ff_idx)])
      else $error("remove left slot valid");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_stall && !cmd.commit) |=> $stable(rsp_ff) || $past(cmd.commit))
      else $error("result changed while held");

endmodule
`default_nettype wire

@@ rtl/core/object_dictionary_table_top.sv @@
// Object dictionary table: top level joining sequencer and datapath.
//
//   channel  direction  ports
//   req      in         req_valid, req_stall, req_word
//   rsp      out        rsp_valid, rsp_stall, rsp_word
//
// A request runs from accept through load, one slot read per cycle, the
// compare of the last slot, a fetch of the matching entry, then commit; the
// next request waits for that. The result is valid the cycle after commit.
// The table is empty right after reset (valid bits clear).
// A held result stalls the next request only when it is still waiting.
`timescale 1ns / 1ps
`default_nettype none
module object_dictionary_table_top #(
   parameter int TABLE_DEPTH = odt_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire odt_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output odt_pkg::rsp_word_type      rsp_word
);

   odt_pkg::cmd_type  cmd;
   odt_pkg::stat_type stat;

   odt_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .cmd(cmd), .stat(stat)
   );

   odt_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
      .clock(clock), .reset(reset),
      .req_word(req_word), .cmd(cmd), .stat(stat),
      .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// Testbench for the object dictionary table: directed and random requests checked by a predictor.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

   localparam int DEPTH = odt_pkg::TABLE_DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 2000000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   odt_pkg::req_word_type req_word;
   logic rsp_valid;
   logic rsp_stall;
   odt_pkg::rsp_word_type rsp_word;

   object_dictionary_table_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word)
   );

   // expected dictionary contents
   logic        od_used[DEPTH];
   logic [23:0] od_key[DEPTH];
   logic [3:0]  od_type[DEPTH];
   logic [2:0]  od_access[DEPTH];
   logic [3:0]  od_size[DEPTH];
   logic [63:0] od_value[DEPTH];

   odt_pkg::rsp_word_type expected_rsp[$];
   int errors = 0;
   longint cycles = 0;
   int burst_left = 0;
   int gap_left = 0;

   // known keys for well-formed traffic
   logic [15:0] key_index[$];
   logic [7:0]  key_sub[$];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [3:0] type_bytes(input logic [3:0] t);
      if (t <= 4'd2) return 4'd1;
      if (t <= 4'd4) return 4'd2;
      if (t <= 4'd7) return 4'd4;
      if (t <= 4'd10) return 4'd8;
      return 4'd0;
   endfunction

   function automatic logic [63:0] low_bytes(input logic [3:0] n);
      logic [63:0] m;
      m = '0;
      for (int b = 0; b < 8; b++)
         if (n > b) m[b*8 +: 8] = 8'hFF;
      return m;
   endfunction

   function automatic int lookup_entry(input logic [23:0] k);
      for (int i = 0; i < DEPTH; i++)
         if (od_used[i] && od_key[i] == k) return i;
      return -1;
   endfunction

   function automatic odt_pkg::rsp_word_type apply_request(input odt_pkg::req_word_type r);
      odt_pkg::rsp_word_type o;
      logic [3:0] tsize;
      logic [3:0] size;
      logic [23:0] k;
      logic [63:0] v;
      int s;
      o = '0;
      k = {r.od_index, r.od_subindex[7:0]};
      if (r.req_type == odt_pkg::REQ_INSERT) begin
         tsize = type_bytes(r.value_kind);
         size = (r.byte_count == 0) ? tsize : r.byte_count;
         if (r.od_subindex > 16'hFF || size == 0) o.status = odt_pkg::ST_INVALID;
         else if (tsize != 0 && tsize != size) o.status = odt_pkg::ST_TYPE;
         else if (size > 8) o.status = odt_pkg::ST_LENGTH;
         else if (lookup_entry(k) >= 0) o.status = odt_pkg::ST_DUP;
         else begin
            s = -1;
            for (int i = 0; i < DEPTH; i++)
               if (!od_used[i] && s < 0) s = i;
            if (s < 0) o.status = odt_pkg::ST_FULL;
            else begin
               od_used[s] = 1'b1;
               od_key[s] = k;
               od_type[s] = r.value_kind;
               od_access[s] = r.access_bits;
               od_size[s] = size;
               od_value[s] = '0;
            end
         end
      end else begin
         s = (r.od_subindex > 16'hFF) ? -1 : lookup_entry(k);
         if (s < 0) o.status = odt_pkg::ST_MISSING;
         else if (r.req_type == odt_pkg::REQ_REMOVE) od_used[s] = 1'b0;
         else if (r.req_type == odt_pkg::REQ_READ) begin
            if (!od_access[s][odt_pkg::ACC_RD]) o.status = odt_pkg::ST_RDENY;
            else if (r.byte_count < od_size[s]) o.status = odt_pkg::ST_LENGTH;
            else begin
               o.read_data = od_value[s] & low_bytes(od_size[s]);
               o.read_size = od_size[s];
            end
         end else begin
            if (!od_access[s][odt_pkg::ACC_WR] || od_access[s][odt_pkg::ACC_CONST])
               o.status = odt_pkg::ST_WDENY;
            else if (r.byte_count != od_size[s]) o.status = odt_pkg::ST_LENGTH;
            else begin
               v = r.write_data & low_bytes(od_size[s]);
               if (od_type[s] == odt_pkg::TYPE_BOOL) od_value[s] = (v != 0) ? 64'd1 : 64'd0;
               else if (od_type[s] <= odt_pkg::TYPE_LAST_STD) od_value[s] = v;
            end
         end
      end
      return o;
   endfunction

   // sender: bursts with random gaps
   task automatic send_request(input odt_pkg::req_word_type r);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
      end
      if (gap_left > 0) begin
         req_valid <= 1'b0;
         repeat (gap_left) @(posedge clock);
      end
      gap_left = 0;
      burst_left--;
      req_valid <= 1'b1;
      req_word <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_rsp.push_back(apply_request(r));
   endtask

   task automatic send_fields(input logic [1:0] op, input logic [15:0] idx,
                              input logic [15:0] sub, input logic [3:0] typ,
                              input logic [2:0] acc, input logic [3:0] cnt,
                              input logic [63:0] data);
      odt_pkg::req_word_type r;
      r.req_type = op;
      r.od_index = idx;
      r.od_subindex = sub;
      r.value_kind = typ;
      r.access_bits = acc;
      r.byte_count = cnt;
      r.write_data = data;
      send_request(r);
   endtask

   // receiver stall pattern and checking
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) rsp_stall <= 1'b0;
      else if (cycles[10:9] == 2'b11) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 99) < (cycles[12] ? 60 : 20));
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            $error("unexpected result word");
            errors++;
         end else begin
            odt_pkg::rsp_word_type e;
            e = expected_rsp.pop_front();
            if (rsp_word.status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_word.status);
               errors++;
            end
            if (rsp_word.read_data !== e.read_data) begin
               $error("read_data expected %h actual %h", e.read_data, rsp_word.read_data);
               errors++;
            end
            if (rsp_word.read_size !== e.read_size) begin
               $error("read_size expected %0d actual %0d", e.read_size, rsp_word.read_size);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic test_insert_checks;
      send_fields(odt_pkg::REQ_INSERT, 16'h1000, 16'h0100, 4'd2, 3'd3, 4'd0, '0);
      send_fields(odt_pkg::REQ_INSERT, 16'h1000, 16'h0000, 4'd14, 3'd3, 4'd0, '0);
      send_fields(odt_pkg::REQ_INSERT, 16'h1000, 16'h0000, 4'd3, 3'd3, 4'd4, '0);
      send_fields(odt_pkg::REQ_INSERT, 16'h1000, 16'h0000, 4'd12, 3'd3, 4'd15, '0);
      send_fields(odt_pkg::REQ_INSERT, 16'hFFFF, 16'h00FF, 4'd10, 3'd7, 4'd0, '0);
      send_fields(odt_pkg::REQ_INSERT, 16'hFFFF, 16'h00FF, 4'd10, 3'd3, 4'd8, '0);
      send_fields(odt_pkg::REQ_INSERT, 16'h0000, 16'h0000, 4'd0, 3'd3, 4'd0, '0);
      send_fields(odt_pkg::REQ_INSERT, 16'h0001, 16'h0000, 4'd15, 3'd3, 4'd3, '0);
   endtask

   task automatic test_access;
      send_fields(odt_pkg::REQ_WRITE, 16'h0000, 16'h0000, 4'd0, 3'd0, 4'd1, 64'hF0);
      send_fields(odt_pkg::REQ_READ, 16'h0000, 16'h0000, 4'd0, 3'd0, 4'd15, '0);
      send_fields(odt_pkg::REQ_WRITE, 16'hFFFF, 16'h00FF, 4'd0, 3'd0, 4'd8, '1);
      send_fields(odt_pkg::REQ_READ, 16'hFFFF, 16'h00FF, 4'd0, 3'd0, 4'd7, '0);
      send_fields(odt_pkg::REQ_WRITE, 16'h0001, 16'h0000, 4'd0, 3'd0, 4'd3, '1);
      send_fields(odt_pkg::REQ_READ, 16'h0001, 16'h0000, 4'd0, 3'd0, 4'd3, '0);
      send_fields(odt_pkg::REQ_WRITE, 16'h0001, 16'h0000, 4'd0, 3'd0, 4'd2, '1);
      send_fields(odt_pkg::REQ_READ, 16'h0000, 16'hFF00, 4'd0, 3'd0, 4'd8, '0);
      send_fields(odt_pkg::REQ_REMOVE, 16'h0000, 16'h0000, 4'd0, 3'd0, 4'd0, '0);
      send_fields(odt_pkg::REQ_REMOVE, 16'h0000, 16'h0000, 4'd0, 3'd0, 4'd0, '0);
   endtask

   task automatic test_full_table;
      for (int i = 0; i < DEPTH + 1; i++)
         send_fields(odt_pkg::REQ_INSERT, 16'h2000, 16'(i), 4'd6, 3'd3, 4'd0, '0);
      for (int i = 0; i < DEPTH + 1; i++)
         send_fields(odt_pkg::REQ_REMOVE, 16'h2000, 16'(i), 4'd0, 3'd0, 4'd0, '0);
   endtask

   task automatic test_random_traffic(input int count);
      odt_pkg::req_word_type r;
      int pick;
      for (int n = 0; n < count; n++) begin
         r.req_type = 2'($urandom_range(0, 3));
         r.value_kind = 4'($urandom_range(0, 15));
         r.access_bits = 3'($urandom_range(0, 7));
         r.write_data = {$urandom, $urandom};
         if ($urandom_range(0, 9) < 8 && key_index.size() > 0) begin
            pick = $urandom_range(0, key_index.size() - 1);
            r.od_index = key_index[pick];
            r.od_subindex = {8'h00, key_sub[pick]};
            if (r.req_type == odt_pkg::REQ_INSERT) r.value_kind = 4'($urandom_range(0, 13));
            r.byte_count = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15))
                           : ((r.req_type == odt_pkg::REQ_INSERT) ? 4'd0
                              : type_bytes(r.value_kind));
            if (r.req_type != odt_pkg::REQ_INSERT && $urandom_range(0, 1)) begin
               int s;
               s = lookup_entry({r.od_index, r.od_subindex[7:0]});
               if (s >= 0) r.byte_count = od_size[s];
            end
         end else begin
            r.od_index = 16'($urandom);
            r.od_subindex = 16'($urandom);
            r.byte_count = 4'($urandom_range(0, 15));
         end
         send_request(r);
      end
   endtask

   initial begin
      for (int i = 0; i < DEPTH; i++) od_used[i] = 1'b0;
      for (int i = 0; i < 80; i++) begin
         key_index.push_back(($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 3))
                             : 16'($urandom));
         key_sub.push_back(8'($urandom));
      end
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_word <= '0;
      rsp_stall <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_insert_checks();
      test_access();
      test_full_table();
      test_random_traffic(1450);
      req_valid <= 1'b0;
      while (expected_rsp.size() > 0) @(posedge clock);
      repeat (2 * DEPTH + 20) @(posedge clock);
      if (errors == 0 && expected_rsp.size() == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule
`default_nettype wire

@@ sim.f @@
rtl/core/odt_pkg.sv
rtl/core/odt_ctrl.sv
rtl/core/odt_datapath.sv
rtl/core/object_dictionary_table_top.sv
sim/testbench.sv
